// ----- hdl/pse_pkg.sv -----
// Shared types, character codes and controller/datapath interface for the postfix evaluator.
`timescale 1ns / 1ps
`default_nettype none
package pse_pkg;

  // Data word width of the stack and of the arithmetic
  localparam int WORD_WIDTH = 32;

  // Width of the stack limit register and its value after reset
  localparam int LIMIT_WIDTH = 5;
  localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = 5'd16;

  // Expression characters
  localparam logic [7:0] CHAR_PLUS  = 8'd43;
  localparam logic [7:0] CHAR_MINUS = 8'd45;
  localparam logic [7:0] CHAR_STAR  = 8'd42;
  localparam logic [7:0] CHAR_SLASH = 8'd47;
  localparam logic [7:0] CHAR_ZERO  = 8'd48;

  typedef enum logic [2:0] {
    OP_PUSH,
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV
  } op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISP,
    S_POP2,
    S_LOAD,
    S_EXEC,
    S_DIV,
    S_PUSH,
    S_PEEK,
    S_EMIT
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic load_sym;
    logic push;
    logic pop;
    logic take_rhs;
    logic take_lhs;
    logic alu;
    logic div_start;
    logic div_take;
    logic peek;
    logic emit;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    op_e  op;
    logic last;
    logic rhs_zero;
    logic div_done;
    logic out_free;
  } sts_t;

  // Classify one expression character
  function automatic op_e decode_op(logic [7:0] code);
    op_e op;
    unique case (code)
      CHAR_PLUS:  op = OP_ADD;
      CHAR_MINUS: op = OP_SUB;
      CHAR_STAR:  op = OP_MUL;
      CHAR_SLASH: op = OP_DIV;
      default:    op = OP_PUSH;
    endcase
    return op;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/pse_div.sv -----
// Radix-2 restoring signed divider, one quotient bit per cycle, truncating toward zero.
`timescale 1ns / 1ps
`default_nettype none
module pse_div (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [pse_pkg::WORD_WIDTH-1:0] dividend_i,
  input  wire logic [pse_pkg::WORD_WIDTH-1:0] divisor_i,
  output logic                               done_o,
  output logic [pse_pkg::WORD_WIDTH-1:0]     quotient_o
);

  localparam int W = pse_pkg::WORD_WIDTH;
  localparam int CntW = $clog2(W + 1);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic            done_q, done_d;
  logic            neg_q;
  logic [W-1:0]    rem_q, quo_q, dvs_q;
  logic [W:0]      rem_sh;
  logic [W:0]      trial;
  logic            ge;
  logic [W-1:0]    mag_a, mag_b;

  // Operand magnitudes; the most negative value maps to itself as an unsigned number
  assign mag_a = dividend_i[W-1] ? (~dividend_i + W'(1)) : dividend_i;
  assign mag_b = divisor_i[W-1] ? (~divisor_i + W'(1)) : divisor_i;

  // One trial subtraction per cycle
  assign rem_sh = {rem_q, quo_q[W-1]};
  assign ge     = rem_sh >= {1'b0, dvs_q};
  assign trial  = rem_sh - {1'b0, dvs_q};

  // Iteration count and done pulse
  always_comb begin
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      cnt_d = CntW'(W);
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  // Shift remainder and quotient
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= mag_a;
      dvs_q <= mag_b;
      neg_q <= dividend_i[W-1] ^ divisor_i[W-1];
    end else if (cnt_q != '0) begin
      rem_q <= ge ? trial[W-1:0] : rem_sh[W-1:0];
      quo_q <= {quo_q[W-2:0], ge};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = neg_q ? (~quo_q + W'(1)) : quo_q;

endmodule
`default_nettype wire

// ----- hdl/pse_ctrl.sv -----
// Sequencing state machine: walks one symbol through pop, execute, push and result steps.
`timescale 1ns / 1ps
`default_nettype none
module pse_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire pse_pkg::sts_t sts_i,
  output pse_pkg::cmd_t      cmd_o
);

  pse_pkg::state_e state_q, state_d;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pse_pkg::S_IDLE: begin
        if (in_valid_i) state_d = pse_pkg::S_DISP;
      end
      pse_pkg::S_DISP: begin
        if (sts_i.op == pse_pkg::OP_PUSH) begin
          state_d = sts_i.last ? pse_pkg::S_PEEK : pse_pkg::S_IDLE;
        end else begin
          state_d = pse_pkg::S_POP2;
        end
      end
      pse_pkg::S_POP2: state_d = pse_pkg::S_LOAD;
      pse_pkg::S_LOAD: state_d = pse_pkg::S_EXEC;
      pse_pkg::S_EXEC: begin
        if (sts_i.op == pse_pkg::OP_DIV && !sts_i.rhs_zero) state_d = pse_pkg::S_DIV;
        else state_d = pse_pkg::S_PUSH;
      end
      pse_pkg::S_DIV: begin
        if (sts_i.div_done) state_d = pse_pkg::S_PUSH;
      end
      pse_pkg::S_PUSH: state_d = sts_i.last ? pse_pkg::S_PEEK : pse_pkg::S_IDLE;
      pse_pkg::S_PEEK: state_d = pse_pkg::S_EMIT;
      pse_pkg::S_EMIT: begin
        if (sts_i.out_free) state_d = pse_pkg::S_IDLE;
      end
      default: state_d = pse_pkg::S_IDLE;
    endcase
  end

  // Command outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      pse_pkg::S_IDLE: begin
        in_ready_o     = 1'b1;
        cmd_o.load_sym = in_valid_i;
      end
      pse_pkg::S_DISP: begin
        if (sts_i.op == pse_pkg::OP_PUSH) cmd_o.push = 1'b1;
        else cmd_o.pop = 1'b1;
      end
      pse_pkg::S_POP2: begin
        cmd_o.take_rhs = 1'b1;
        cmd_o.pop      = 1'b1;
      end
      pse_pkg::S_LOAD: cmd_o.take_lhs = 1'b1;
      pse_pkg::S_EXEC: begin
        if (sts_i.op == pse_pkg::OP_DIV && !sts_i.rhs_zero) cmd_o.div_start = 1'b1;
        else cmd_o.alu = 1'b1;
      end
      pse_pkg::S_DIV: cmd_o.div_take = sts_i.div_done;
      pse_pkg::S_PUSH: cmd_o.push = 1'b1;
      pse_pkg::S_PEEK: cmd_o.peek = 1'b1;
      pse_pkg::S_EMIT: cmd_o.emit = sts_i.out_free;
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pse_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/pse_dp.sv -----
// Datapath: stack memory, operand and accumulator registers, ALU, divider, flags, output register.
`timescale 1ns / 1ps
`default_nettype none
module pse_dp #(
  parameter int STACK_DEPTH = 16
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire pse_pkg::cmd_t                         cmd_i,
  output pse_pkg::sts_t                              sts_o,
  input  wire logic [7:0]                            symbol_code_i,
  input  wire logic                                  last_symbol_i,
  input  wire logic                                  cfg_we_i,
  input  wire logic [pse_pkg::LIMIT_WIDTH-1:0]       cfg_wdata_i,
  input  wire logic                                  out_ready_i,
  output logic                                       out_valid_o,
  output logic signed [pse_pkg::WORD_WIDTH-1:0]      result_value_o,
  output logic                                       overflow_seen_o,
  output logic                                       underflow_seen_o,
  output logic                                       divide_by_zero_seen_o
);

  localparam int W  = pse_pkg::WORD_WIDTH;
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int LW = (CW > pse_pkg::LIMIT_WIDTH) ? CW : pse_pkg::LIMIT_WIDTH;

  logic [W-1:0]  mem [STACK_DEPTH];
  logic [W-1:0]  rd_q;
  logic          hit_q;

  logic [7:0]    sym_q;
  logic          last_q;
  logic [W-1:0]  lhs_q, rhs_q, acc_q;
  logic [CW-1:0] count_q;
  logic [CW-1:0] cnt_m1;
  logic [pse_pkg::LIMIT_WIDTH-1:0] lim_q;
  logic          ovf_q, udf_q, dz_q;
  logic          out_valid_q;
  logic [W-1:0]  res_q;
  logic          res_ovf_q, res_udf_q, res_dz_q;

  pse_pkg::op_e  op;
  logic          empty, full;
  logic [LW-1:0] lim_ext, cnt_ext, depth_ext;
  logic          wr_en, rd_en;
  logic [W-1:0]  wr_data;
  logic [W-1:0]  operand;
  logic [W-1:0]  popped;
  logic [W-1:0]  div_q;
  logic          div_done;

  // Stack occupancy against the effective limit
  assign empty     = (count_q == '0);
  assign cnt_m1    = count_q - CW'(1);
  assign lim_ext   = (lim_q == '0) ? LW'(1) : LW'(lim_q);
  assign cnt_ext   = LW'(count_q);
  assign depth_ext = LW'(STACK_DEPTH);
  assign full      = (cnt_ext >= depth_ext) || (cnt_ext >= lim_ext);

  assign op      = pse_pkg::decode_op(sym_q);
  assign operand = {{(W - 8){1'b0}}, sym_q} - W'(pse_pkg::CHAR_ZERO);
  assign wr_data = (op == pse_pkg::OP_PUSH) ? operand : acc_q;
  assign wr_en   = cmd_i.push && !full;
  assign rd_en   = (cmd_i.pop || cmd_i.peek) && !empty;
  assign popped  = hit_q ? rd_q : '1;

  // Stack memory, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[count_q[AW-1:0]] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[cnt_m1[AW-1:0]];
    end
  end

  // Stack pointer, flags, limit register and read-hit marker
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      lim_q   <= pse_pkg::LIMIT_RESET;
      ovf_q   <= 1'b0;
      udf_q   <= 1'b0;
      dz_q    <= 1'b0;
      hit_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        lim_q <= cfg_wdata_i;
      end
      if (cmd_i.pop || cmd_i.peek) begin
        hit_q <= !empty;
      end
      if (cmd_i.emit) begin
        count_q <= '0;
        ovf_q   <= 1'b0;
        udf_q   <= 1'b0;
        dz_q    <= 1'b0;
      end else begin
        if (cmd_i.pop) begin
          if (empty) udf_q <= 1'b1;
          else count_q <= cnt_m1;
        end
        if (cmd_i.push) begin
          if (full) ovf_q <= 1'b1;
          else count_q <= count_q + CW'(1);
        end
        if (cmd_i.alu && op == pse_pkg::OP_DIV) begin
          dz_q <= 1'b1;
        end
      end
    end
  end

  // Symbol, operands and accumulator
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_sym) begin
      sym_q  <= symbol_code_i;
      last_q <= last_symbol_i;
    end
    if (cmd_i.take_rhs) rhs_q <= popped;
    if (cmd_i.take_lhs) lhs_q <= popped;
    if (cmd_i.alu) begin
      case (op)
        pse_pkg::OP_ADD: acc_q <= lhs_q + rhs_q;
        pse_pkg::OP_SUB: acc_q <= lhs_q - rhs_q;
        pse_pkg::OP_MUL: acc_q <= W'(lhs_q * rhs_q);
        default:         acc_q <= '0;
      endcase
    end else if (cmd_i.div_take) begin
      acc_q <= div_q;
    end
  end

  pse_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (lhs_q),
    .divisor_i  (rhs_q),
    .done_o     (div_done),
    .quotient_o (div_q)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      res_q     <= popped;
      res_ovf_q <= ovf_q;
      res_udf_q <= udf_q;
      res_dz_q  <= dz_q;
    end
  end

  assign sts_o.op       = op;
  assign sts_o.last     = last_q;
  assign sts_o.rhs_zero = (rhs_q == '0);
  assign sts_o.div_done = div_done;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o           = out_valid_q;
  assign result_value_o        = res_q;
  assign overflow_seen_o       = res_ovf_q;
  assign underflow_seen_o      = res_udf_q;
  assign divide_by_zero_seen_o = res_dz_q;

endmodule
`default_nettype wire

// ----- hdl/postfix_stack_evaluator_unit.sv -----
// Top level of the postfix expression evaluator: controller plus stack datapath.
// Throughput: one symbol at a time. An operand is pushed at dispatch; + - * pop both
// operands, execute and push the result; / waits in the one-bit-per-cycle divider before
// the push, unless the divisor is zero. A symbol marked last adds a top-of-stack read, then
// the result sits in an output register; the next symbol is taken once it is loaded there.
// Reset (async, active low) empties the stack, clears the flags and sets the limit to 16;
// stack memory contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module postfix_stack_evaluator_unit #(
  parameter int STACK_DEPTH = 16
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  in_valid_i,
  output logic                                       in_ready_o,
  input  wire logic [7:0]                            symbol_code_i,
  input  wire logic                                  last_symbol_i,
  output logic                                       out_valid_o,
  input  wire logic                                  out_ready_i,
  output logic signed [pse_pkg::WORD_WIDTH-1:0]      result_value_o,
  output logic                                       overflow_seen_o,
  output logic                                       underflow_seen_o,
  output logic                                       divide_by_zero_seen_o,
  input  wire logic                                  cfg_we_i,
  input  wire logic [pse_pkg::LIMIT_WIDTH-1:0]       cfg_wdata_i
);

  pse_pkg::cmd_t cmd;
  pse_pkg::sts_t sts;

  pse_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pse_dp #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cmd_i                 (cmd),
    .sts_o                 (sts),
    .symbol_code_i         (symbol_code_i),
    .last_symbol_i         (last_symbol_i),
    .cfg_we_i              (cfg_we_i),
    .cfg_wdata_i           (cfg_wdata_i),
    .out_ready_i           (out_ready_i),
    .out_valid_o           (out_valid_o),
    .result_value_o        (result_value_o),
    .overflow_seen_o       (overflow_seen_o),
    .underflow_seen_o      (underflow_seen_o),
    .divide_by_zero_seen_o (divide_by_zero_seen_o)
  );

endmodule
`default_nettype wire
